// ===== rtl/opwft_pkg.sv =====
// Shared types, constants and register codes for the OOK pulse-width frame transmitter.
package opwft_pkg;

	localparam int ID_BITS     = 27;
	localparam int KEY_BITS    = 8;
	localparam int FRAME_BITS  = ID_BITS + KEY_BITS;
	localparam int LEN_W       = 16;
	localparam int REP_W       = 6;
	localparam int BIT_IDX_W   = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// input tdata: start_req, remote_id, key_code from bit 0 up, padded to bytes
	localparam int IN_USED_W   = 1 + ID_BITS + KEY_BITS;
	localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
	localparam int ID_LSB      = 1;
	localparam int KEY_LSB     = ID_LSB + ID_BITS;
	// output tdata: line_level, busy_res from bit 0 up, padded to a byte
	localparam int OUT_TDATA_W = 8;

	localparam logic [LEN_W-1:0] SHORT_LEN_RST     = LEN_W'(350);
	localparam logic [LEN_W-1:0] LONG_LEN_RST      = LEN_W'(1050);
	localparam logic [LEN_W-1:0] SYNC_HIGH_LEN_RST = LEN_W'(350);
	localparam logic [LEN_W-1:0] SYNC_LOW_LEN_RST  = LEN_W'(6000);
	localparam logic [REP_W-1:0] REPEAT_TOTAL_RST  = REP_W'(26);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT_LEN     = 3'd0,
		REG_LONG_LEN      = 3'd1,
		REG_SYNC_HIGH_LEN = 3'd2,
		REG_SYNC_LOW_LEN  = 3'd3,
		REG_REPEAT_TOTAL  = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'b0001,
		PH_SYNC_HIGH = 4'b0010,
		PH_SYNC_LOW  = 4'b0100,
		PH_DATA      = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [LEN_W-1:0] short_len;
		logic [LEN_W-1:0] long_len;
		logic [LEN_W-1:0] sync_high_len;
		logic [LEN_W-1:0] sync_low_len;
		logic [REP_W-1:0] repeat_total;
	} cfg_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic done_pulse;
	} tick_res_t;

endpackage

// ===== rtl/opwft_cfg.sv =====
// Configuration register file for the OOK pulse-width frame transmitter.
module opwft_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [opwft_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [opwft_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output opwft_pkg::cfg_t                    cfg
);

	opwft_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_len     <= opwft_pkg::SHORT_LEN_RST;
			cfg_q.long_len      <= opwft_pkg::LONG_LEN_RST;
			cfg_q.sync_high_len <= opwft_pkg::SYNC_HIGH_LEN_RST;
			cfg_q.sync_low_len  <= opwft_pkg::SYNC_LOW_LEN_RST;
			cfg_q.repeat_total  <= opwft_pkg::REPEAT_TOTAL_RST;
		end else if (cfg_we) begin
			unique case (opwft_pkg::cfg_reg_t'(cfg_index))
				opwft_pkg::REG_SHORT_LEN:     cfg_q.short_len     <= cfg_wdata;
				opwft_pkg::REG_LONG_LEN:      cfg_q.long_len      <= cfg_wdata;
				opwft_pkg::REG_SYNC_HIGH_LEN: cfg_q.sync_high_len <= cfg_wdata;
				opwft_pkg::REG_SYNC_LOW_LEN:  cfg_q.sync_low_len  <= cfg_wdata;
				opwft_pkg::REG_REPEAT_TOTAL:
					cfg_q.repeat_total <= cfg_wdata[opwft_pkg::REP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/opwft_seq.sv =====
// Frame sequencer: phase, segment timer, bit and repeat counters, one tick per step.
module opwft_seq (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step_en,
	input  logic                               start_req,
	input  logic [opwft_pkg::ID_BITS-1:0]      remote_id,
	input  logic [opwft_pkg::KEY_BITS-1:0]     key_code,
	input  opwft_pkg::cfg_t                    cfg,
	output opwft_pkg::tick_res_t               res
);

	localparam int FB = opwft_pkg::FRAME_BITS;
	localparam int LW = opwft_pkg::LEN_W;
	localparam int RW = opwft_pkg::REP_W;
	localparam int BW = opwft_pkg::BIT_IDX_W;

	opwft_pkg::phase_t phase_q, phase_d, ph;
	logic [LW-1:0]     tick_q, tick_d, tick_w;
	logic [BW-1:0]     bit_q, bit_d, bit_w, bit_inc;
	logic [RW-1:0]     rep_q, rep_d, rep_w, rep_inc, reps;
	logic [FB-1:0]     frame_q, frame_d, frame_w;
	logic              lvl_q, lvl_d, lvl_w;
	logic [LW-1:0]     seg_len;
	logic              seg_end;

	always_comb begin
		// a start is folded into the working state so its tick is the first sync tick
		ph      = phase_q;
		tick_w  = tick_q;
		bit_w   = bit_q;
		rep_w   = rep_q;
		frame_w = frame_q;
		lvl_w   = lvl_q;
		if (phase_q == opwft_pkg::PH_IDLE && start_req) begin
			ph      = opwft_pkg::PH_SYNC_HIGH;
			tick_w  = '0;
			bit_w   = '0;
			rep_w   = '0;
			frame_w = {remote_id, key_code};
			lvl_w   = 1'b1;
		end

		phase_d = ph;
		tick_d  = tick_w;
		bit_d   = bit_w;
		rep_d   = rep_w;
		frame_d = frame_w;
		lvl_d   = lvl_w;
		res     = '0;
		seg_len = cfg.short_len;
		bit_inc = bit_w + BW'(1);
		rep_inc = rep_w + RW'(1);
		reps    = (cfg.repeat_total == '0) ? RW'(1) : cfg.repeat_total;

		unique case (ph)
			opwft_pkg::PH_IDLE: begin
				seg_len = cfg.short_len;
			end
			opwft_pkg::PH_SYNC_HIGH: begin
				seg_len        = cfg.sync_high_len;
				res.line_level = 1'b1;
			end
			opwft_pkg::PH_SYNC_LOW: begin
				seg_len        = cfg.sync_low_len;
				res.line_level = 1'b0;
			end
			opwft_pkg::PH_DATA: begin
				// frame rotates so the current bit always sits at the top
				seg_len        = frame_w[FB-1] ? cfg.long_len : cfg.short_len;
				res.line_level = lvl_w;
			end
			default: seg_len = cfg.short_len;
		endcase

		// a zero length gives the same compare result as a length of one
		seg_end = ({1'b0, tick_w} + (LW+1)'(1)) >= {1'b0, seg_len};

		if (ph != opwft_pkg::PH_IDLE) begin
			res.busy_res = 1'b1;
			if (seg_end) begin
				tick_d = '0;
				unique case (ph)
					opwft_pkg::PH_SYNC_HIGH: phase_d = opwft_pkg::PH_SYNC_LOW;
					opwft_pkg::PH_SYNC_LOW: begin
						phase_d = opwft_pkg::PH_DATA;
						bit_d   = '0;
						lvl_d   = 1'b1;
					end
					default: begin
						bit_d   = bit_inc;
						lvl_d   = ~lvl_w;
						frame_d = {frame_w[FB-2:0], frame_w[FB-1]};
						if (bit_inc >= BW'(FB)) begin
							bit_d = '0;
							rep_d = rep_inc;
							if (rep_inc >= reps || rep_inc == '0) begin
								res.done_pulse = 1'b1;
								phase_d        = opwft_pkg::PH_IDLE;
								lvl_d          = 1'b0;
								rep_d          = '0;
							end else begin
								phase_d = opwft_pkg::PH_SYNC_HIGH;
							end
						end
					end
				endcase
			end else begin
				tick_d = tick_w + LW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= opwft_pkg::PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			rep_q   <= '0;
			frame_q <= '0;
			lvl_q   <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			rep_q   <= rep_d;
			frame_q <= frame_d;
			lvl_q   <= lvl_d;
		end
	end

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q < BW'(FB))
		else $error("bit index past end of frame");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.done_pulse |=> phase_q == opwft_pkg::PH_IDLE)
		else $error("sequencer not idle after done");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && phase_q == opwft_pkg::PH_IDLE && start_req
		|=> phase_q != opwft_pkg::PH_IDLE)
		else $error("start did not begin a transmission");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == opwft_pkg::PH_IDLE |-> !lvl_q && rep_q == '0 && tick_q == '0)
		else $error("idle state not cleared");

endmodule

// ===== rtl/ook_pulse_width_frame_transmitter_top.sv =====
// OOK pulse-width frame transmitter: stream ports, config port and output register.
//
// Each input transaction is one tick of the transmitted waveform. The slave side
// carries start_req, remote_id and key_code; while idle, a tick with start_req set
// latches the identity and key and starts a transmission: per frame a sync pulse
// (sync_high_len ticks high, sync_low_len ticks low) then 35 bits MSB first, id
// then key, each bit short_len or long_len ticks, the level toggling per bit and
// starting high. repeat_total frames run back to back, then the line rests low.
// Every input transaction yields exactly one output transaction: line_level and
// busy_res in tdata, done_pulse on tlast (final tick of the last frame).
// The result of a tick sits in the output register on the cycle after its input
// is accepted. Throughput is one tick per cycle while the receiver keeps up; the
// sequencer state and output register are updated together on each accept.
// When the receiver stalls, the output register holds and tready drops until the
// held transaction is taken; in the same cycle it is taken a new tick is accepted.
// Reset clears the sequencer to idle, loads the register defaults and empties the
// output register. Configuration should only be written while idle.
module ook_pulse_width_frame_transmitter_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [opwft_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [opwft_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [0] start_req, [27:1] remote_id, [35:28] key_code, rest zero
	input  logic [opwft_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [0] line_level, [1] busy_res, rest zero
	output logic [opwft_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                 m_axis_tlast
);

	opwft_pkg::cfg_t      cfg;
	opwft_pkg::tick_res_t res;
	logic                 step_en;
	logic                 out_valid_q;
	logic                 line_q, busy_q, done_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign step_en       = s_axis_tvalid && s_axis_tready;

	opwft_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	opwft_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.start_req (s_axis_tdata[0]),
		.remote_id (s_axis_tdata[opwft_pkg::ID_LSB +: opwft_pkg::ID_BITS]),
		.key_code  (s_axis_tdata[opwft_pkg::KEY_LSB +: opwft_pkg::KEY_BITS]),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			line_q <= res.line_level;
			busy_q <= res.busy_res;
			done_q <= res.done_pulse;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(opwft_pkg::OUT_TDATA_W-2){1'b0}}, busy_q, line_q};
	assign m_axis_tlast  = done_q;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1])
		else $error("done without busy");

	a_idle_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[1] |-> !m_axis_tdata[0])
		else $error("line high while idle");

	a_one_out_per_in: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> m_axis_tvalid)
		else $error("accepted tick produced no result");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the OOK pulse-width frame transmitter: tick-accurate line prediction.
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int REPORT_CAP = 40;

	localparam int LW  = opwft_pkg::LEN_W;
	localparam int RW  = opwft_pkg::REP_W;
	localparam int BW  = opwft_pkg::BIT_IDX_W;
	localparam int FB  = opwft_pkg::FRAME_BITS;
	localparam int IDW = opwft_pkg::ID_BITS;
	localparam int KW  = opwft_pkg::KEY_BITS;
	localparam int DW  = opwft_pkg::CFG_DATA_W;
	localparam int ITW = opwft_pkg::IN_TDATA_W;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [opwft_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [DW-1:0] cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// [0] start_req, [27:1] remote_id, [35:28] key_code, [39:36] zero
	logic [ITW-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// [0] line_level, [1] busy_res, [7:2] zero
	logic [opwft_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	ook_pulse_width_frame_transmitter_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	// line predictor state
	opwft_pkg::cfg_t cur_cfg;
	opwft_pkg::phase_t tx_phase;
	logic [LW-1:0] seg_ticks;
	logic [BW-1:0] bit_pos;
	logic [RW-1:0] frame_count;
	logic [FB-1:0] frame_word;
	logic level_now;

	opwft_pkg::tick_res_t line_expect_q[$];
	opwft_pkg::tick_res_t want;

	int send_idle_pct;
	int stall_pct;
	int hold_left;
	int fail_count;
	int ticks_sent;
	int results_seen;
	int bursts_sent;
	int settings_loaded;
	int cycle_count;

	function automatic opwft_pkg::tick_res_t next_line_sample(input logic start,
			input logic [IDW-1:0] id, input logic [KW-1:0] key);
		opwft_pkg::tick_res_t r;
		logic [LW-1:0] seg_len;
		logic [RW-1:0] reps;
		logic cur_bit;
		r = '0;
		if (tx_phase == opwft_pkg::PH_IDLE) begin
			if (!start)
				return r;
			frame_word = {id, key};
			tx_phase = opwft_pkg::PH_SYNC_HIGH;
			seg_ticks = '0;
			bit_pos = '0;
			frame_count = '0;
			level_now = 1'b1;
		end
		r.busy_res = 1'b1;
		case (tx_phase)
			opwft_pkg::PH_SYNC_HIGH: begin
				r.line_level = 1'b1;
				seg_len = cur_cfg.sync_high_len;
			end
			opwft_pkg::PH_SYNC_LOW: begin
				r.line_level = 1'b0;
				seg_len = cur_cfg.sync_low_len;
			end
			default: begin
				cur_bit = (int'(bit_pos) < FB) ?
					frame_word[FB - 1 - int'(bit_pos)] : 1'b0;
				r.line_level = level_now;
				seg_len = cur_bit ? cur_cfg.long_len : cur_cfg.short_len;
			end
		endcase
		// a zero length still lasts one tick
		if (seg_len == '0)
			seg_len = LW'(1);
		if (int'(seg_ticks) + 1 >= int'(seg_len)) begin
			seg_ticks = '0;
			case (tx_phase)
				opwft_pkg::PH_SYNC_HIGH: begin
					tx_phase = opwft_pkg::PH_SYNC_LOW;
				end
				opwft_pkg::PH_SYNC_LOW: begin
					tx_phase = opwft_pkg::PH_DATA;
					bit_pos = '0;
					level_now = 1'b1;
				end
				default: begin
					bit_pos = bit_pos + BW'(1);
					level_now = ~level_now;
					if (int'(bit_pos) >= FB) begin
						reps = (cur_cfg.repeat_total == '0) ? RW'(1) : cur_cfg.repeat_total;
						frame_count = frame_count + RW'(1);
						bit_pos = '0;
						if (frame_count >= reps || frame_count == '0) begin
							r.done_pulse = 1'b1;
							tx_phase = opwft_pkg::PH_IDLE;
							level_now = 1'b0;
							frame_count = '0;
						end else begin
							tx_phase = opwft_pkg::PH_SYNC_HIGH;
						end
					end
				end
			endcase
		end else begin
			seg_ticks = seg_ticks + LW'(1);
		end
		return r;
	endfunction

	function automatic opwft_pkg::cfg_t make_cfg(input int short_v, input int long_v,
			input int sync_hi, input int sync_lo, input int reps);
		opwft_pkg::cfg_t c;
		c.short_len = LW'(short_v);
		c.long_len = LW'(long_v);
		c.sync_high_len = LW'(sync_hi);
		c.sync_low_len = LW'(sync_lo);
		c.repeat_total = RW'(reps);
		return c;
	endfunction

	function automatic opwft_pkg::cfg_t random_settings();
		opwft_pkg::cfg_t c;
		c = make_cfg($urandom_range(0, 2), $urandom_range(0, 3), $urandom_range(0, 3),
			$urandom_range(0, 3), $urandom_range(0, 2));
		// now and then a segment runs longer
		if ($urandom_range(0, 7) == 0)
			c.sync_low_len = LW'($urandom_range(4, 40));
		if ($urandom_range(0, 7) == 0)
			c.long_len = LW'($urandom_range(4, 12));
		if ($urandom_range(0, 9) == 0)
			c.repeat_total = RW'($urandom_range(3, 6));
		return c;
	endfunction

	function automatic logic [IDW-1:0] pick_id();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return IDW'($urandom);
		endcase
	endfunction

	function automatic logic [KW-1:0] pick_key();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return KW'($urandom);
		endcase
	endfunction

	// one tick transaction; tvalid is left high for the caller's next tick
	task automatic send_tick(input logic start, input logic [IDW-1:0] id,
			input logic [KW-1:0] key);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= ITW'({$urandom, $urandom});
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(ITW - opwft_pkg::IN_USED_W){1'b0}}, key, id, start};
		do
			@(posedge clk);
		while (!s_axis_tready);
		line_expect_q.push_back(next_line_sample(start, id, key));
		ticks_sent++;
	endtask

	// stop offering and wait until every tick result is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (line_expect_q.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_config(input opwft_pkg::cfg_t c);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= opwft_pkg::REG_SHORT_LEN;
		cfg_wdata <= c.short_len;
		@(posedge clk);
		cfg_index <= opwft_pkg::REG_LONG_LEN;
		cfg_wdata <= c.long_len;
		@(posedge clk);
		cfg_index <= opwft_pkg::REG_SYNC_HIGH_LEN;
		cfg_wdata <= c.sync_high_len;
		@(posedge clk);
		cfg_index <= opwft_pkg::REG_SYNC_LOW_LEN;
		cfg_wdata <= c.sync_low_len;
		@(posedge clk);
		// upper bits of the repeat write are don't-care and get masked
		cfg_index <= opwft_pkg::REG_REPEAT_TOTAL;
		cfg_wdata <= {(DW - RW)'($urandom), c.repeat_total};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_cfg = c;
		settings_loaded++;
	endtask

	// start tick, then ticks until the line goes idle; some busy ticks carry ignored starts
	task automatic run_transmission(input logic [IDW-1:0] id,
			input logic [KW-1:0] key, input int busy_start_pct);
		send_tick(1'b1, id, key);
		bursts_sent++;
		while (tx_phase != opwft_pkg::PH_IDLE)
			send_tick($urandom_range(0, 99) < busy_start_pct, IDW'($urandom),
				KW'($urandom));
	endtask

	task automatic test_idle_ticks();
		send_tick(1'b0, '1, '1);
		send_tick(1'b0, '0, '0);
		send_tick(1'b0, IDW'($urandom), KW'($urandom));
	endtask

	task automatic test_edge_values();
		load_config(make_cfg(1, 2, 1, 2, 1));
		run_transmission('1, '1, 100);
		// next start lands right on the tick after done
		run_transmission('0, '0, 0);
		run_transmission(27'h5555555, 8'hA5, 50);
	endtask

	task automatic test_zero_registers();
		load_config(make_cfg(0, 0, 0, 0, 0));
		run_transmission(pick_id(), pick_key(), 30);
	endtask

	task automatic test_repeat_count();
		load_config(make_cfg(0, 1, 1, 0, 8));
		run_transmission(IDW'($urandom), KW'($urandom), 20);
	endtask

	task automatic test_length_extremes();
		// all-ones frame never uses the short length
		load_config(make_cfg(65535, 1, 2, 1, 2));
		run_transmission('1, '1, 10);
		// all-zeros frame never uses the long length
		load_config(make_cfg(1, 65535, 1, 2, 2));
		run_transmission('0, '0, 10);
		load_config(make_cfg(1, 2, 20, 30, 1));
		run_transmission(IDW'($urandom), KW'($urandom), 5);
	endtask

	task automatic test_stall_and_pause();
		int n;
		send_idle_pct = 0;
		stall_pct = 0;
		load_config(make_cfg(1, 2, 2, 3, 2));
		hold_left = 250;
		send_tick(1'b1, IDW'($urandom), KW'($urandom));
		bursts_sent++;
		n = 0;
		while (tx_phase != opwft_pkg::PH_IDLE) begin
			// sender pauses mid-frame until the line output catches up
			if (n == 60) begin
				s_axis_tvalid <= 1'b0;
				do
					@(posedge clk);
				while (line_expect_q.size() != 0);
			end
			send_tick(1'($urandom_range(0, 1)), IDW'($urandom), KW'($urandom));
			n++;
		end
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall, input int budget);
		int first_tick;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		first_tick = ticks_sent;
		load_config(random_settings());
		while (ticks_sent - first_tick < budget) begin
			if ($urandom_range(0, 1) == 0)
				load_config(random_settings());
			repeat ($urandom_range(0, 3))
				send_tick(1'b0, IDW'($urandom), KW'($urandom));
			run_transmission(pick_id(), pick_key(), $urandom_range(0, 100));
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: random stalls, or a counted hold-off when one is requested
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (line_expect_q.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_CAP)
					$display("%0t: unexpected output transaction, tdata %h tlast %b",
						$time, m_axis_tdata, m_axis_tlast);
			end else begin
				want = line_expect_q.pop_front();
				if (m_axis_tdata[0] !== want.line_level || m_axis_tdata[1] !== want.busy_res ||
						m_axis_tlast !== want.done_pulse || m_axis_tdata[7:2] !== '0) begin
					fail_count++;
					if (fail_count <= REPORT_CAP) begin
						$display("%0t: result %0d expected line %b busy %b done %b pad 00",
							$time, results_seen, want.line_level, want.busy_res,
							want.done_pulse);
						$display("%0t: result %0d actual   line %b busy %b done %b pad %h",
							$time, results_seen, m_axis_tdata[0], m_axis_tdata[1],
							m_axis_tlast, m_axis_tdata[7:2]);
					end
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ook_pulse_width_frame_transmitter_top: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = opwft_pkg::REG_SHORT_LEN;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		fail_count = 0;
		ticks_sent = 0;
		results_seen = 0;
		bursts_sent = 0;
		settings_loaded = 0;
		cur_cfg = '{short_len: opwft_pkg::SHORT_LEN_RST, long_len: opwft_pkg::LONG_LEN_RST,
			sync_high_len: opwft_pkg::SYNC_HIGH_LEN_RST,
			sync_low_len: opwft_pkg::SYNC_LOW_LEN_RST,
			repeat_total: opwft_pkg::REPEAT_TOTAL_RST};
		tx_phase = opwft_pkg::PH_IDLE;
		seg_ticks = '0;
		bit_pos = '0;
		frame_count = '0;
		frame_word = '0;
		level_now = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_ticks();
		test_edge_values();
		test_zero_registers();
		test_repeat_count();
		test_length_extremes();
		test_stall_and_pause();
		test_random_traffic(0, 0, 100);
		test_random_traffic(61, 0, 100);
		test_random_traffic(0, 61, 100);
		test_random_traffic(38, 38, 100);

		drain();
		if (line_expect_q.size() != 0) begin
			fail_count++;
			$display("%0t: %0d tick results never arrived", $time, line_expect_q.size());
		end
		$display("Covered %0d ticks in %0d transmissions over %0d register settings",
			ticks_sent, bursts_sent, settings_loaded);
		$display("incl. zero and 65535 lengths, repeated frames, ignored starts, gaps, stalls");
		if (fail_count == 0)
			$display("ook_pulse_width_frame_transmitter_top: match");
		else
			$display("ook_pulse_width_frame_transmitter_top: mismatch");
		$finish;
	end

endmodule
